// File: src/cleb_pkg.sv
// Shared types and constants for the cursor line-edit buffer.
`default_nettype none
package cleb_pkg;

    // Command codes carried on the cmd field.
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Key bytes with an editing meaning; every other byte is inserted.
    localparam logic [7:0] KEY_BACK  = 8'd66;   // 'B'
    localparam logic [7:0] KEY_LEFT  = 8'd76;   // 'L'
    localparam logic [7:0] KEY_RIGHT = 8'd82;   // 'R'

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_FLUSH
    } state_t;

endpackage
`default_nettype wire

// File: src/cleb_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while re is low; same-address access returns old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: src/cursor_line_edit_buffer_core.sv
// Cursor line-edit buffer: gap buffer over one synchronous RAM.
//
// A line of up to CAPACITY bytes is held as a gap buffer in a single RAM with
// a registered read port: text before the cursor at the low end, text after
// the cursor at the high end. Key beats (cmd = 0) produce no output beat.
// Insert writes at the cursor and backspace only lowers the count; left and
// right move one byte across the gap with a read followed by a write in
// ST_MOVE. Inserting into a full buffer drops the byte and sets a sticky
// overflow flag. A flush beat (cmd = 1) snapshots and clears the counts and
// flag, then walks the text through the RAM read port, one byte per cycle
// when out_ready stays high; an empty buffer gives a single beat with
// text_empty set. The final beat carries last_char, and every beat of a flush
// carries the overflow flag as it stood at the flush. The input side is ready
// only while no key move or flush walk is in progress; an output register
// decouples the walk from a stalled consumer, and key beats are taken while
// the last flush beat still waits there. RAM contents need no clearing: only
// entries holding text are ever read.
`default_nettype none
module cursor_line_edit_buffer_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire logic [7:0] key,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] text_char,
    output logic            last_char,
    output logic            text_empty,
    output logic            overflowed
);
    import cleb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t        state_reg, state_next;
    logic [CW-1:0] before_reg, before_next;
    logic [CW-1:0] after_reg, after_next;
    logic          drop_reg, drop_next;

    // key move: pending write address and direction
    logic [AW-1:0] mv_waddr_reg, mv_waddr_next;
    logic          mv_left_reg, mv_left_next;

    // flush walk snapshot
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] walk_total_reg, walk_total_next;
    logic [CW-1:0] walk_before_reg, walk_before_next;
    logic          walk_drop_reg, walk_drop_next;
    logic          pend_reg, pend_next;         // RAM read data waits
    logic          pend_last_reg, pend_last_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    text_char_reg, text_char_next;
    logic          last_char_reg, last_char_next;
    logic          text_empty_reg, text_empty_next;
    logic          overflowed_reg, overflowed_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [CW-1:0] total;
    logic [CW-1:0] walk_idx;
    logic          in_fire, out_free, load_out, issue;

    cleb_ram #(
        .WIDTH(8),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign total    = before_reg + after_reg;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign load_out = pend_reg && out_free;
    assign issue    = (state_reg == ST_FLUSH) && (k_reg < walk_total_reg)
                      && (!pend_reg || load_out);
    // k-th text byte: before part from the bottom, after part from the top
    assign walk_idx = (k_reg < walk_before_reg) ? k_reg
                                                : (CAP_C - walk_total_reg + k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            before_reg    <= '0;
            after_reg     <= '0;
            drop_reg      <= 1'b0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            before_reg    <= before_next;
            after_reg     <= after_next;
            drop_reg      <= drop_next;
            k_reg         <= k_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_waddr_reg    <= mv_waddr_next;
        mv_left_reg     <= mv_left_next;
        walk_total_reg  <= walk_total_next;
        walk_before_reg <= walk_before_next;
        walk_drop_reg   <= walk_drop_next;
        pend_last_reg   <= pend_last_next;
        text_char_reg   <= text_char_next;
        last_char_reg   <= last_char_next;
        text_empty_reg  <= text_empty_next;
        overflowed_reg  <= overflowed_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        before_next      = before_reg;
        after_next       = after_reg;
        drop_next        = drop_reg;
        mv_waddr_next    = mv_waddr_reg;
        mv_left_next     = mv_left_reg;
        k_next           = k_reg;
        walk_total_next  = walk_total_reg;
        walk_before_next = walk_before_reg;
        walk_drop_next   = walk_drop_reg;
        pend_next        = pend_reg;
        pend_last_next   = pend_last_reg;
        out_valid_next   = out_valid_reg;
        text_char_next   = text_char_reg;
        last_char_next   = last_char_reg;
        text_empty_next  = text_empty_reg;
        overflowed_next  = overflowed_reg;
        ram_we           = 1'b0;
        ram_waddr        = AW'(before_reg);
        ram_wdata        = key;
        ram_re           = 1'b0;
        ram_raddr        = AW'(walk_idx);

        // output register drains independently of the FSM
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd == CMD_FLUSH)
                    begin
                        walk_total_next  = total;
                        walk_before_next = before_reg;
                        walk_drop_next   = drop_reg;
                        k_next           = '0;
                        before_next      = '0;
                        after_next       = '0;
                        drop_next        = 1'b0;
                        state_next       = ST_FLUSH;
                    end
                    else
                    begin
                        case (key)
                            KEY_BACK:
                            begin
                                if (before_reg != '0)
                                begin
                                    before_next = before_reg - ONE_C;
                                end
                            end
                            KEY_LEFT:
                            begin
                                if (before_reg != '0)
                                begin
                                    ram_re        = 1'b1;
                                    ram_raddr     = AW'(before_reg - ONE_C);
                                    mv_waddr_next = AW'(CAP_C - after_reg - ONE_C);
                                    mv_left_next  = 1'b1;
                                    state_next    = ST_MOVE;
                                end
                            end
                            KEY_RIGHT:
                            begin
                                if (after_reg != '0)
                                begin
                                    ram_re        = 1'b1;
                                    ram_raddr     = AW'(CAP_C - after_reg);
                                    mv_waddr_next = AW'(before_reg);
                                    mv_left_next  = 1'b0;
                                    state_next    = ST_MOVE;
                                end
                            end
                            default:
                            begin
                                if (total < CAP_C)
                                begin
                                    ram_we      = 1'b1;
                                    ram_waddr   = AW'(before_reg);
                                    ram_wdata   = key;
                                    before_next = before_reg + ONE_C;
                                end
                                else
                                begin
                                    drop_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end

            ST_MOVE:
            begin
                // byte read last cycle lands on the far side of the gap
                ram_we    = 1'b1;
                ram_waddr = mv_waddr_reg;
                ram_wdata = ram_rdata;
                if (mv_left_reg)
                begin
                    before_next = before_reg - ONE_C;
                    after_next  = after_reg + ONE_C;
                end
                else
                begin
                    before_next = before_reg + ONE_C;
                    after_next  = after_reg - ONE_C;
                end
                state_next = ST_IDLE;
            end

            ST_FLUSH:
            begin
                if (walk_total_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        text_char_next  = 8'd0;
                        last_char_next  = 1'b1;
                        text_empty_next = 1'b1;
                        overflowed_next = walk_drop_reg;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    if (load_out)
                    begin
                        out_valid_next  = 1'b1;
                        text_char_next  = ram_rdata;
                        last_char_next  = pend_last_reg;
                        text_empty_next = 1'b0;
                        overflowed_next = walk_drop_reg;
                    end
                    if (issue)
                    begin
                        ram_re         = 1'b1;
                        ram_raddr      = AW'(walk_idx);
                        pend_next      = 1'b1;
                        pend_last_next = ((k_reg + ONE_C) == walk_total_reg);
                        k_next         = k_reg + ONE_C;
                    end
                    else
                    begin
                        if (load_out)
                        begin
                            pend_next = 1'b0;
                        end
                        if ((k_reg == walk_total_reg) && (!pend_reg || load_out))
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign text_char  = text_char_reg;
    assign last_char  = last_char_reg;
    assign text_empty = text_empty_reg;
    assign overflowed = overflowed_reg;

    // Text never outgrows the store.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, before_reg} + {1'b0, after_reg}) <= {1'b0, CAP_C})
        else $error("gap buffer counts exceed capacity");

    // The flush walk only reads; no write may disturb the text under it.
    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> !ram_we)
        else $error("store written during flush walk");

    // Pending read data exists only inside a flush walk.
    a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_FLUSH))
        else $error("pending read data outside flush walk");

    // A walk read address stays inside the store.
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (walk_idx < CAP_C))
        else $error("flush read address out of range");

endmodule
`default_nettype wire

// File: verif/cursor_line_edit_buffer_core_tb.sv
// Self-checking testbench for the cursor line-edit buffer core.
`default_nettype none
module cursor_line_edit_buffer_core_tb;
    import cleb_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int PHASE_BEATS = 130;      // random input beats per idling phase
    localparam int CYCLE_LIMIT = 400000;   // generous: slowest legal run is far below

    // One output beat of a flush.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       ovf;
    } text_beat_t;

    // Directed stimulus row. Rows with a typed result carry it in "want";
    // every other row is checked against the line model below.
    typedef struct packed {
        logic       c;
        logic [7:0] k;
        logic       typed;
        text_beat_t want;
    } dir_row_t;

    localparam text_beat_t UNTYPED   = '{8'h00, 1'b0, 1'b0, 1'b0};
    localparam text_beat_t EMPTY_OUT = '{8'h00, 1'b1, 1'b1, 1'b0};
    localparam int         DIR_ROWS  = 23;

    // Directed part: every special case of the editing rules, the extreme key
    // bytes and both commands. Most rows note the cursor position after them.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_FLUSH, 8'h00,     1'b1, EMPTY_OUT},             // flush straight out of reset
        '{CMD_KEY,   KEY_BACK,  1'b0, UNTYPED},               // backspace at start: no-op
        '{CMD_KEY,   KEY_LEFT,  1'b0, UNTYPED},               // left at start: no-op
        '{CMD_KEY,   KEY_RIGHT, 1'b0, UNTYPED},               // right at end: no-op
        '{CMD_FLUSH, 8'hFF,     1'b1, EMPTY_OUT},             // key byte ignored on flush
        '{CMD_KEY,   8'hFF,     1'b0, UNTYPED},               // 0xFF is a plain character
        '{CMD_FLUSH, 8'h5A,     1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{CMD_KEY,   8'h00,     1'b0, UNTYPED},               // "00|"
        '{CMD_KEY,   8'h41,     1'b0, UNTYPED},               // "00 A|"
        '{CMD_KEY,   8'h43,     1'b0, UNTYPED},               // "00 A C|"
        '{CMD_KEY,   KEY_LEFT,  1'b0, UNTYPED},               // "00 A|C"
        '{CMD_KEY,   KEY_LEFT,  1'b0, UNTYPED},               // "00|A C"
        '{CMD_KEY,   KEY_BACK,  1'b0, UNTYPED},               // "|A C"
        '{CMD_KEY,   KEY_LEFT,  1'b0, UNTYPED},               // left at start again
        '{CMD_KEY,   KEY_RIGHT, 1'b0, UNTYPED},               // "A|C"
        '{CMD_KEY,   KEY_RIGHT, 1'b0, UNTYPED},               // "A C|"
        '{CMD_KEY,   KEY_RIGHT, 1'b0, UNTYPED},               // right at end with text
        '{CMD_KEY,   KEY_BACK,  1'b0, UNTYPED},               // backspace at end: "A|"
        '{CMD_KEY,   8'h7F,     1'b0, UNTYPED},               // "A 7F|"
        '{CMD_KEY,   KEY_LEFT,  1'b0, UNTYPED},               // "A|7F"
        '{CMD_KEY,   8'h80,     1'b0, UNTYPED},               // "A 80|7F"
        '{CMD_FLUSH, 8'h00,     1'b0, UNTYPED},               // three beats, text split by gap
        '{CMD_FLUSH, 8'h00,     1'b1, EMPTY_OUT}              // flush cleared everything
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       cmd = CMD_KEY;
    logic [7:0] key = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] text_char;
    logic       last_char;
    logic       text_empty;
    logic       overflowed;

    cursor_line_edit_buffer_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .text_char (text_char),
        .last_char (last_char),
        .text_empty(text_empty),
        .overflowed(overflowed)
    );

    // 2-unit clock period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Line model: gap buffer mirror. Text before the cursor lives at the low
    // end of line_mem, text after the cursor at the high end.
    logic [7:0]  line_mem [CAPACITY];
    int unsigned head_len = 0;          // chars before the cursor
    int unsigned tail_len = 0;          // chars after the cursor
    bit          lost_key = 1'b0;       // sticky: an insert hit a full line

    text_beat_t  flush_text_q [$];      // flush beats still owed by the DUT
    int          mismatches = 0;
    int          beats_sent = 0;
    int          cycles = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;

    // Apply one accepted input beat to the line model; a flush queues the
    // beats it must produce.
    function automatic void edit_line(input logic c, input logic [7:0] k);
        int unsigned total;
        int unsigned idx;
        text_beat_t  b;
        total = head_len + tail_len;
        if (c == CMD_FLUSH)
        begin
            if (total == 0)
            begin
                b = '{8'h00, 1'b1, 1'b1, lost_key};
                flush_text_q.push_back(b);
            end
            else
            begin
                for (int i = 0; i < total; i++)
                begin
                    idx  = (i < head_len) ? i : CAPACITY - total + i;
                    b    = '{line_mem[idx], (i == total - 1), 1'b0, lost_key};
                    flush_text_q.push_back(b);
                end
            end
            head_len = 0;
            tail_len = 0;
            lost_key = 1'b0;
        end
        else
        begin
            case (k)
                KEY_BACK:
                    if (head_len > 0)
                        head_len--;
                KEY_LEFT:
                    if (head_len > 0)
                    begin
                        line_mem[CAPACITY - tail_len - 1] = line_mem[head_len - 1];
                        head_len--;
                        tail_len++;
                    end
                KEY_RIGHT:
                    if (tail_len > 0)
                    begin
                        line_mem[head_len] = line_mem[CAPACITY - tail_len];
                        head_len++;
                        tail_len--;
                    end
                default:
                    if (total < CAPACITY)
                    begin
                        line_mem[head_len] = k;
                        head_len++;
                    end
                    else
                        lost_key = 1'b1;
            endcase
        end
    endfunction

    // Drive one input beat. Inputs move on the falling edge; acceptance is
    // seen on the rising edge. Optional random idle cycles come first, and
    // valid holds with a stable payload until in_ready.
    task automatic send_beat(input logic c, input logic [7:0] k,
                             input logic typed, input text_beat_t want);
        int n0;
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        n0 = flush_text_q.size();
        edit_line(c, k);
        // Typed rows: the hand-written beat replaces the model's one.
        if (typed)
        begin
            while (flush_text_q.size() > n0)
                void'(flush_text_q.pop_back());
            flush_text_q.push_back(want);
        end
        beats_sent++;
    endtask

    task automatic send_key(input logic [7:0] k);
        send_beat(CMD_KEY, k, 1'b0, UNTYPED);
    endtask

    task automatic send_flush();
        send_beat(CMD_FLUSH, 8'($urandom_range(255)), 1'b0, UNTYPED);
    endtask

    // Drop valid and hold off until every owed flush beat has come out.
    task automatic drain_line();
        @(negedge clk);
        in_valid <= 1'b0;
        while (flush_text_q.size() != 0)
            @(posedge clk);
    endtask

    // Key mix for ordinary editing: plenty of edits, extremes now and then.
    function automatic logic [7:0] pick_edit_key();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return KEY_BACK;
        else if (r < 24)
            return KEY_LEFT;
        else if (r < 36)
            return KEY_RIGHT;
        else if (r < 42)
            return 8'hFF;
        else if (r < 46)
            return 8'h00;
        return 8'($urandom_range(255));
    endfunction

    // Ordinary session: a short or medium run of edits, then a flush. A zero
    // length session gives back-to-back flushes.
    task automatic edit_session();
        int r;
        int len;
        r   = $urandom_range(99);
        len = (r < 10) ? 0 : (r < 80) ? $urandom_range(12, 1) : $urandom_range(40, 13);
        repeat (len)
            send_key(pick_edit_key());
        send_flush();
    endtask

    // Fill session: type until an insert is dropped, poke around in the full
    // line (moves work, more inserts are lost), then flush all of it.
    task automatic fill_session();
        int r;
        while (!lost_key)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_key(KEY_LEFT);
            else if (r < 20)
                send_key(KEY_RIGHT);
            else
                send_key(8'($urandom_range(255)));
        end
        repeat ($urandom_range(6, 2))
        begin
            r = $urandom_range(2);
            send_key(r == 0 ? KEY_LEFT : r == 1 ? KEY_RIGHT : 8'($urandom_range(255)));
        end
        send_flush();
    endtask

    // Receiver: random backpressure, decided on the falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Output checker: every accepted output beat against the oldest owed one.
    always @(posedge clk)
    begin
        text_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (flush_text_q.size() == 0)
            begin
                $display("%0t: unexpected output beat, expected none, actual char %0h",
                         $time, text_char);
                mismatches++;
            end
            else
            begin
                want = flush_text_q.pop_front();
                compare_field("text_char", want.ch, text_char);
                compare_field("last_char", want.last, last_char);
                compare_field("text_empty", want.empty, text_empty);
                compare_field("overflowed", want.ovf, overflowed);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int phase_start;
        foreach (line_mem[i])
            line_mem[i] = 8'h00;

        // Reset held low from time zero, released on a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling.
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_rows[i].c, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].want);
        drain_line();

        // Random part in three idling phases: light sender gaps with heavy
        // backpressure, then the reverse, then full throughput. Each phase
        // starts with one overflow session and ends fully drained.
        for (int phase = 0; phase < 3; phase++)
        begin
            snd_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 57 : 0;
            rcv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 14 : 0;
            phase_start  = beats_sent;
            fill_session();
            while (beats_sent - phase_start < PHASE_BEATS)
                edit_session();
            drain_line();
        end

        // Quiet tail: long enough for any stray beat to surface.
        repeat (CAPACITY + 8) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: cursor_line_edit_buffer_core.f
src/cleb_pkg.sv
src/cleb_ram.sv
src/cursor_line_edit_buffer_core.sv
verif/cursor_line_edit_buffer_core_tb.sv
